>>> src/svt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the sorted variable table
// Holds the table size, the operation codes and the transaction token that
// travels down the row of table cells.
// ----------------------------------------------------------------------------
package svt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int NUM_W         = 16;
   localparam int VAL_W         = 64;
   localparam int KIND_W        = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_GET    = 2'd1,
      KIND_SET    = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Transaction token handed from cell to cell
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [NUM_W-1:0] number;  // key; for insert the entry being carried
      logic [VAL_W-1:0] value;   // carried value, or value read by get
      logic             done;    // slot placed, or match found
   } token_type;

   // Finished result of one transaction
   typedef struct packed {
      logic             status;
      logic [VAL_W-1:0] read_value;
   } result_type;

endpackage

>>> src/svt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_cell: one slot of the sorted variable table
// Holds one entry (number and value), applies the passing token to it and
// hands the token to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module svt_cell (
   input  logic               clock,
   input  logic               reset,
   input  svt_pkg::token_type tok_i,
   output svt_pkg::token_type tok_o
);
   import svt_pkg::*;

   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] num_in;
   logic [VAL_W-1:0] val_ff;
   logic [VAL_W-1:0] val_in;
   token_type        tok_ff;
   token_type        tok_in;
   logic             match;

   assign match = (num_ff == tok_i.number);

   // Apply the token to this slot
   always_comb begin
      num_in = num_ff;
      val_in = val_ff;
      tok_in = tok_i;
      if (tok_i.valid) begin
         unique case (tok_i.kind)
            KIND_INSERT: begin
               // Place here once the slot is empty or not smaller, then shift
               if (tok_i.done || (num_ff == '0) || (num_ff >= tok_i.number)) begin
                  num_in        = tok_i.number;
                  val_in        = tok_i.value;
                  tok_in.number = num_ff;
                  tok_in.value  = val_ff;
                  tok_in.done   = 1'b1;
               end
            end
            KIND_GET: begin
               if (!tok_i.done && match) begin
                  tok_in.value = val_ff;
                  tok_in.done  = 1'b1;
               end
            end
            KIND_SET: begin
               if (!tok_i.done && match) begin
                  val_in      = tok_i.value;
                  tok_in.done = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the entry and pass the token on
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         num_ff       <= num_in;
         tok_ff.valid <= tok_in.valid;
      end
      val_ff        <= val_in;
      tok_ff.kind   <= tok_in.kind;
      tok_ff.number <= tok_in.number;
      tok_ff.value  <= tok_in.value;
      tok_ff.done   <= tok_in.done;
   end

   assign tok_o = tok_ff;

endmodule

>>> src/svt_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svt_result_buf: result output register with a holding stage
// Takes the result leaving the last cell, parks it while the output register
// is occupied, and drives the result stream.
// ----------------------------------------------------------------------------
module svt_result_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  svt_pkg::result_type res,
   output logic                hand_off,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output svt_pkg::result_type rsp
);
   import svt_pkg::*;

   result_type pend_ff;
   logic       pend_valid_ff;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign hand_off = rsp_free && (pend_valid_ff || res_valid);

   // Control: move pending or fresh result into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (hand_off) begin
            rsp_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else begin
            if (rsp_tready) begin
               rsp_valid_ff <= 1'b0;
            end
            if (res_valid) begin
               pend_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (hand_off) begin
         rsp_ff <= pend_valid_ff ? pend_ff : res;
      end
      if (res_valid && !rsp_free) begin
         pend_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

>>> src/sorted_variable_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_variable_table: sorted table of numbered 64-bit variables
// Row of table cells with insert, get and set transactions.
// ----------------------------------------------------------------------------
// One transaction at a time travels down a row of TABLE_ENTRIES cells, one
// cell per cycle. The first cell registers the transaction at the accepting
// edge, and each cell in turn registers it before the result reaches the
// result register. Ready drops at acceptance and rises again in the same
// cycle that the result appears in the output register, even while that
// result still waits to be taken, so a new transaction is accepted only
// after the previous result has moved into the output register. A stalled
// response register keeps ready low until the result can move on. The
// table is empty after reset. Insert keeps the entries sorted by number
// and drops the last entry when the table is full; number 0 is never
// stored or found, and kind 3 answers status 1.
// ----------------------------------------------------------------------------
module sorted_variable_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // [15:0] var_number, [79:16] var_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] read_value
   output logic        rsp_tuser    // [0] status
);
   import svt_pkg::*;

   token_type  tok [0:TABLE_ENTRIES];
   token_type  head_tok;
   logic       busy_ff;
   logic       accept;
   logic       hand_off;
   kind_type   req_kind;
   token_type  last_tok;
   result_type res;
   result_type rsp;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;

   // Number zero matches nothing and cannot be stored: treat as no-op
   always_comb begin
      req_kind = kind_type'(req_tuser);
      if (req_tdata[NUM_W-1:0] == '0) begin
         req_kind = KIND_NONE;
      end
      head_tok.valid  = accept;
      head_tok.kind   = req_kind;
      head_tok.number = req_tdata[NUM_W-1:0];
      head_tok.value  = req_tdata[NUM_W +: VAL_W];
      head_tok.done   = 1'b0;
   end

   assign tok[0] = head_tok;

   // Row of table cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      svt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (tok[i]),
         .tok_o (tok[i+1])
      );
   end

   // Form the result from the token leaving the row
   assign last_tok       = tok[TABLE_ENTRIES];
   assign res.status     = !last_tok.done;
   assign res.read_value = (last_tok.kind == KIND_GET && last_tok.done) ?
                           last_tok.value : '0;

   // Track the transaction in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (hand_off) begin
         busy_ff <= 1'b0;
      end
   end

   svt_result_buf u_result_buf (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (last_tok.valid),
      .res        (res),
      .hand_off   (hand_off),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp.read_value;
   assign rsp_tuser = rsp.status;

endmodule

>>> dv/sorted_variable_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_variable_table_tb: self-checking bench for the sorted variable table
// Drives insert, get and set transactions through the request stream and
// checks every response against a behavioral table kept in the bench. Starts
// with directed corner cases, then runs random phases with and without idle
// cycles on the request side and back-pressure on the response side.
// ----------------------------------------------------------------------------
module sorted_variable_table_tb;

   import svt_pkg::*;

   localparam int  CLOCK_HALF   = 5;
   localparam int  RESET_CYCLES = 10;
   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  DRAIN_CYCLES = 60;
   localparam int  PHASE_ITEMS  = 250;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct {
      kind_type         kind;
      logic [NUM_W-1:0] number;
      logic [VAL_W-1:0] value;
   } table_request_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;    // [15:0] var_number, [79:16] var_value
   logic [1:0]  req_tuser  = '0;    // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;          // [63:0] read_value
   logic        rsp_tuser;          // [0] status

   // Bench copy of the table contents
   logic [NUM_W-1:0] slot_number [TABLE_ENTRIES];
   logic [VAL_W-1:0] slot_value  [TABLE_ENTRIES];

   table_request_type pending_requests [$];
   result_type        expected_replies [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   sorted_variable_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #CLOCK_HALF clock = ~clock;

   // Apply one transaction to the bench table and return its response
   function automatic result_type apply_table_op(kind_type kind, logic [NUM_W-1:0] number,
                                                 logic [VAL_W-1:0] value);
      result_type reply;
      int         pos;
      int         hit;
      reply.status     = STATUS_FAIL;
      reply.read_value = '0;
      hit = TABLE_ENTRIES;
      if (number != 0) begin
         for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (slot_number[i] == number) hit = i;
         end
      end
      case (kind)
         KIND_INSERT: begin
            pos = 0;
            while (pos < TABLE_ENTRIES && slot_number[pos] != 0 && slot_number[pos] < number)
               pos++;
            if (number != 0 && pos < TABLE_ENTRIES) begin
               // shift the tail up; the last entry falls off
               for (int j = TABLE_ENTRIES - 1; j > pos; j--) begin
                  slot_number[j] = slot_number[j-1];
                  slot_value[j]  = slot_value[j-1];
               end
               slot_number[pos] = number;
               slot_value[pos]  = value;
               reply.status     = STATUS_OK;
            end
         end
         KIND_GET: begin
            if (hit < TABLE_ENTRIES) begin
               reply.status     = STATUS_OK;
               reply.read_value = slot_value[hit];
            end
         end
         KIND_SET: begin
            if (hit < TABLE_ENTRIES) begin
               slot_value[hit] = value;
               reply.status    = STATUS_OK;
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic queue_request(kind_type kind, logic [NUM_W-1:0] number,
                                logic [VAL_W-1:0] value);
      table_request_type item;
      item.kind   = kind;
      item.number = number;
      item.value  = value;
      pending_requests.push_back(item);
   endtask

   // Hold until every queued transaction has been answered
   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(negedge clock);
   endtask

   // Keys mostly from a small pool so that gets and sets hit and the table fills
   function automatic logic [NUM_W-1:0] pick_number();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return slot_number[$urandom_range(0, TABLE_ENTRIES - 1)];
      if (r < 75) return NUM_W'($urandom_range(1, 40));
      if (r < 80) return '0;
      if (r < 85) return '1;
      return NUM_W'($urandom);
   endfunction

   task automatic queue_random_items(int count);
      int               r;
      kind_type         kind;
      logic [VAL_W-1:0] value;
      logic [NUM_W-1:0] number;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35)      kind = KIND_INSERT;
         else if (r < 65) kind = KIND_GET;
         else if (r < 95) kind = KIND_SET;
         else             kind = KIND_NONE;
         r = $urandom_range(0, 19);
         if (r == 0)      value = '0;
         else if (r == 1) value = '1;
         else             value = {$urandom, $urandom};
         number = pick_number();
         queue_request(kind, number, value);
         // follow about half of the inserts with an access to the same key
         if (kind == KIND_INSERT && $urandom_range(0, 1) == 1)
            queue_request(($urandom_range(0, 1) == 1) ? KIND_GET : KIND_SET, number,
                          {$urandom, $urandom});
      end
   endtask

   // Request driver: hold each transaction until accepted, predict on acceptance
   always @(posedge clock) begin : drive_requests
      table_request_type item;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_replies.push_back(apply_table_op(kind_type'(req_tuser),
                                                      req_tdata[15:0], req_tdata[79:16]));
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               item = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {item.value, item.number};
               req_tuser  <= item.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin : check_responses
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", VAL_W'(rsp_tuser), VAL_W'(want.status));
               if (rsp_tdata !== want.read_value)
                  report_mismatch("read_value", rsp_tdata, want.read_value);
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         slot_number[i] = '0;
         slot_value[i]  = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table, number zero and the unused kind
      queue_request(KIND_GET, 16'd1, '0);
      queue_request(KIND_SET, 16'd1, 64'h0123_4567_89ab_cdef);
      queue_request(KIND_INSERT, 16'd0, '1);
      queue_request(KIND_GET, 16'd0, '0);
      queue_request(KIND_SET, 16'd0, '1);
      queue_request(KIND_NONE, 16'd5, '1);
      // Extremes, then a duplicate key that must shadow the older entry
      queue_request(KIND_INSERT, 16'hffff, '1);
      queue_request(KIND_INSERT, 16'd1000, 64'haaaa_aaaa_aaaa_aaaa);
      queue_request(KIND_INSERT, 16'd1000, 64'h5555_5555_5555_5555);
      queue_request(KIND_GET, 16'd1000, '0);
      queue_request(KIND_SET, 16'd1000, 64'h8000_0000_0000_0001);
      queue_request(KIND_GET, 16'd1000, '1);
      queue_request(KIND_GET, 16'hffff, '0);
      // Fill the table, overflow inside it, then insert past the end
      for (int k = 1; k <= 13; k++)
         queue_request(KIND_INSERT, NUM_W'(k), {$urandom, $urandom});
      queue_request(KIND_INSERT, 16'd14, '0);
      queue_request(KIND_INSERT, 16'hffff, '1);
      queue_request(KIND_GET, 16'hffff, '0);
      wait_until_drained();

      // Random phases; each drains fully before the next starts
      send_idle_pct = 0;  recv_stall_pct = 0;
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
      send_idle_pct = 54; recv_stall_pct = 0;
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
      send_idle_pct = 0;  recv_stall_pct = 54;
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
      send_idle_pct = 31; recv_stall_pct = 31;
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
      send_idle_pct = 0;  recv_stall_pct = 0;
      queue_random_items(PHASE_ITEMS / 2);
      wait_until_drained();

      // Catch any stray response after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
